// ===== src/multichannel_moving_average_core_assert.svh =====
// ----------------------------------------------------------------------------
// multichannel moving average assertion macros
// Shared assertion forms used by the moving average core and its divider.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_MOVING_AVERAGE_CORE_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define MMA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define MMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg
// Field widths, defaults and shared types of the multichannel moving average.
// ----------------------------------------------------------------------------
package mma_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int CHAN_W         = 4;
	localparam int WIN_W          = 7;
	localparam int FILL_W         = 7;
	localparam int WIN_RESET      = 8;
	localparam int CHANNELS_DEF   = 16;
	localparam int WINDOW_MAX_DEF = 64;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CHAN_W-1:0]          chan_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== src/mma_in_if.sv =====
// ----------------------------------------------------------------------------
// mma_in_if
// Sample channel: valid/ready handshake carrying channel tag and sample.
// ----------------------------------------------------------------------------
interface mma_in_if import mma_pkg::*; ();

	logic    valid;
	logic    ready;
	chan_t   channel;
	sample_t sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink (input valid, input channel, input sample, output ready);

endinterface

// ===== src/mma_out_if.sv =====
// ----------------------------------------------------------------------------
// mma_out_if
// Result channel: valid/ready handshake carrying channel tag and mean.
// ----------------------------------------------------------------------------
interface mma_out_if import mma_pkg::*; ();

	logic    valid;
	logic    ready;
	chan_t   out_channel;
	sample_t average;

	modport source (output valid, output out_channel, output average, input ready);
	modport sink (input valid, input out_channel, input average, output ready);

endinterface

// ===== src/mma_serial_div.sv =====
// ----------------------------------------------------------------------------
// mma_serial_div
// Restoring divider, one quotient bit per cycle on unsigned magnitudes.
// ----------------------------------------------------------------------------
`include "multichannel_moving_average_core_assert.svh"

module mma_serial_div import mma_pkg::*; #(
	parameter int DVD_W = SAMPLE_W + 6,
	parameter int DVS_W = FILL_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output div_stat_t        stat
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] div_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   rem2;
	logic [DVS_W:0]   diff;
	logic             ge;

	// partial remainder with the next dividend bit shifted in
	assign rem2 = {rem_q, dvd_q[DVD_W-1]};
	assign diff = rem2 - {1'b0, div_q};
	assign ge   = rem2 >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits replace dividend bits from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : rem2[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`MMA_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q, "divider not busy after start")
	`MMA_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q && !busy_q, "done not a pulse")
	`MMA_ASSERT_SAME(a_rem_below, clk, arst_n, busy_q, rem_q < div_q, "remainder not below divisor")

endmodule

// ===== src/multichannel_moving_average_core.sv =====
// ----------------------------------------------------------------------------
// multichannel_moving_average_core
// Per-channel moving average over a programmable window of recent samples.
// ----------------------------------------------------------------------------
// samples carries a channel tag and a signed Q8.8 sample; averages returns the
// channel tag with the truncated mean of that channel's held samples, exactly
// one result item per sample item. cfg_wr_en/cfg_wr_data set window_size
// (0 acts as 1, values above WINDOW_MAX clamp) and clear every channel's
// history; write it only while the block is idle.
// One item is worked at a time: a new item is taken only once the result of the
// last one has been loaded into the output register. Each item ends with the
// bit-serial divider, one quotient bit per cycle over the SUM_W-bit running sum.
// Reset clears all channels and loads window_size with 8; no clearing pass is
// needed, per-channel valid bits mark untouched state as empty.
// The result sits in an output register; while the receiver stalls the next
// item is still accepted and worked, and only its result waits for the slot.
// ----------------------------------------------------------------------------
`include "multichannel_moving_average_core_assert.svh"

module multichannel_moving_average_core import mma_pkg::*; #(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [WIN_W-1:0] cfg_wr_data,
	mma_in_if.sink           samples,
	mma_out_if.source        averages
);

	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PTR_W      = $clog2(WINDOW_MAX);
	localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_MAX);
	localparam int ADDR_W     = $clog2(CHANNELS * WINDOW_MAX);
	localparam int CMP_W      = ($clog2(WINDOW_MAX + 1) > WIN_W) ? $clog2(WINDOW_MAX + 1) : WIN_W;
	localparam int PS_W       = CMP_W + 1;
	localparam int CHAN_CODES = 1 << CHAN_W;
	localparam int WIN_INIT   = (WIN_RESET > WINDOW_MAX) ? WINDOW_MAX : WIN_RESET;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_LOAD = 9'b000000010,
		ST_SLOT = 9'b000000100,
		ST_HIST = 9'b000001000,
		ST_SUB  = 9'b000010000,
		ST_ADD  = 9'b000100000,
		ST_WB   = 9'b001000000,
		ST_DIV  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	logic [CH_W-1:0]         ch_map [CHAN_CODES];
	logic [CH_W-1:0]         ch_sel;
	logic                    accept;
	logic                    out_load;

	logic [WIN_W-1:0]        win_q;
	logic [CHANNELS-1:0]     chv_q;

	chan_t                   ch_field_q;
	logic [CH_W-1:0]         ch_q;
	sample_t                 samp_q;

	logic [FILL_W-1:0]       fill_mem [CHANNELS];
	logic [PTR_W-1:0]        ptr_mem [CHANNELS];
	logic signed [SUM_W-1:0] sum_mem [CHANNELS];
	sample_t                 hist_mem [CHANNELS * WINDOW_MAX];

	logic [FILL_W-1:0]       fill_rd_q;
	logic [PTR_W-1:0]        ptr_rd_q;
	logic signed [SUM_W-1:0] sum_rd_q;
	logic                    vld_rd_q;
	sample_t                 hist_rd_q;

	logic [FILL_W-1:0]       fill_q;
	logic [PTR_W-1:0]        ptr_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [PTR_W-1:0]        slot_q;
	logic                    full_q;
	logic                    neg_q;

	logic                    full_nxt;
	logic [PS_W-1:0]         psum;
	logic [PS_W-1:0]         win_ext;
	logic [PS_W-1:0]         slot_inc;
	logic [PTR_W-1:0]        slot_nxt;
	logic [ADDR_W-1:0]       hist_addr;
	logic signed [SUM_W-1:0] old_ext;
	logic [SUM_W-1:0]        mag;

	logic                    div_start;
	logic [SUM_W-1:0]        quot;
	div_stat_t               div_stat;

	logic                    avg_vld_q;
	chan_t                   ochan_q;
	sample_t                 avg_q;

	// channel tag folded onto the channels that exist
	for (genvar i = 0; i < CHAN_CODES; i++) begin : g_chmap
		assign ch_map[i] = CH_W'(i % CHANNELS);
	end

	assign ch_sel   = ch_map[samples.channel];
	assign accept   = samples.valid && samples.ready;
	assign out_load = (state_q == ST_OUT) && (!avg_vld_q || averages.ready);

	// ring slot: append after the held samples, or overwrite the oldest
	assign full_nxt = fill_q >= win_q;
	assign win_ext  = PS_W'(win_q);
	assign psum     = PS_W'(ptr_q) + PS_W'(fill_q);
	assign slot_nxt = full_nxt ? ptr_q :
		((psum >= win_ext) ? PTR_W'(psum - win_ext) : PTR_W'(psum));
	assign slot_inc = PS_W'(slot_q) + PS_W'(1);

	assign hist_addr = ADDR_W'(ch_q) * ADDR_W'(WINDOW_MAX) + ADDR_W'(slot_q);
	assign old_ext   = full_q ? SUM_W'(hist_rd_q) : '0;
	assign mag       = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign div_start = (state_q == ST_WB);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_nxt = ST_LOAD;
			ST_LOAD: state_nxt = ST_SLOT;
			ST_SLOT: state_nxt = ST_HIST;
			ST_HIST: state_nxt = ST_SUB;
			ST_SUB:  state_nxt = ST_ADD;
			ST_ADD:  state_nxt = ST_WB;
			ST_WB:   state_nxt = ST_DIV;
			ST_DIV:  if (div_stat.done) state_nxt = ST_OUT;
			ST_OUT:  if (out_load) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			win_q     <= WIN_W'(WIN_INIT);
			chv_q     <= '0;
			avg_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				chv_q <= '0;
				if (cfg_wr_data == '0) begin
					win_q <= WIN_W'(1);
				end else if (CMP_W'(cfg_wr_data) > CMP_W'(WINDOW_MAX)) begin
					win_q <= WIN_W'(WINDOW_MAX);
				end else begin
					win_q <= cfg_wr_data;
				end
			end else if (state_q == ST_WB) begin
				chv_q[ch_q] <= 1'b1;
			end
			if (out_load) begin
				avg_vld_q <= 1'b1;
			end else if (averages.ready) begin
				avg_vld_q <= 1'b0;
			end
		end
	end

	// channel state memory, registered read on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			fill_rd_q <= fill_mem[ch_sel];
			ptr_rd_q  <= ptr_mem[ch_sel];
			sum_rd_q  <= sum_mem[ch_sel];
		end
		if (state_q == ST_WB) begin
			fill_mem[ch_q] <= fill_q;
			ptr_mem[ch_q]  <= ptr_q;
			sum_mem[ch_q]  <= sum_q;
		end
	end

	// history memory, old entry read as the new one is written
	always_ff @(posedge clk) begin
		if (state_q == ST_HIST) begin
			hist_rd_q           <= hist_mem[hist_addr];
			hist_mem[hist_addr] <= samp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_field_q <= samples.channel;
			ch_q       <= ch_sel;
			samp_q     <= samples.sample;
			vld_rd_q   <= chv_q[ch_sel];
		end
		unique case (state_q)
			ST_LOAD: begin
				fill_q <= vld_rd_q ? fill_rd_q : '0;
				ptr_q  <= vld_rd_q ? ptr_rd_q : '0;
				sum_q  <= vld_rd_q ? sum_rd_q : '0;
			end
			ST_SLOT: begin
				slot_q <= slot_nxt;
				full_q <= full_nxt;
			end
			ST_HIST: begin
				if (!full_q) begin
					fill_q <= fill_q + FILL_W'(1);
				end else begin
					ptr_q <= (slot_inc == win_ext) ? '0 : PTR_W'(slot_inc);
				end
			end
			ST_SUB: sum_q <= sum_q - old_ext;
			ST_ADD: sum_q <= sum_q + SUM_W'(samp_q);
			ST_WB:  neg_q <= sum_q[SUM_W-1];
			default: ;
		endcase
		if (out_load) begin
			ochan_q <= ch_field_q;
			avg_q   <= neg_q ? SAMPLE_W'(-quot[SAMPLE_W-1:0]) : quot[SAMPLE_W-1:0];
		end
	end

	mma_serial_div #(
		.DVD_W(SUM_W),
		.DVS_W(FILL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (fill_q),
		.quotient (quot),
		.stat     (div_stat)
	);

	assign samples.ready        = (state_q == ST_IDLE);
	assign averages.valid       = avg_vld_q;
	assign averages.out_channel = ochan_q;
	assign averages.average     = avg_q;

	`MMA_ASSERT_NEXT(a_accept_load, clk, arst_n, accept, state_q == ST_LOAD, "accept did not start work")
	`MMA_ASSERT_SAME(a_slot_in_win, clk, arst_n, state_q == ST_HIST, CMP_W'(slot_q) < CMP_W'(win_q), "ring slot outside window")
	`MMA_ASSERT_SAME(a_fill_range, clk, arst_n, state_q == ST_WB, fill_q != '0 && fill_q <= win_q, "fill count out of range")
	`MMA_ASSERT_SAME(a_win_range, clk, arst_n, 1'b1, win_q != '0 && CMP_W'(win_q) <= CMP_W'(WINDOW_MAX), "window out of range")

endmodule
